FILE: design/fbes_pkg.sv
// Shared types, sizes and helpers of the frame button edge sampler.
// Used by fbes_ring, fbes_ctrl and frame_button_edge_sampler; no dependencies.
package fbes_pkg;

   localparam int SAMPLE_SLOTS = 16;
   localparam int PAD_COUNT    = 4;
   localparam int SLOT_W       = $clog2(SAMPLE_SLOTS);
   localparam int BTN_W        = 16;
   localparam int SAMPLE_W     = 4 * BTN_W;

   // Item kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [BTN_W-1:0] pad0_buttons;
      logic [BTN_W-1:0] pad1_buttons;
      logic [BTN_W-1:0] pad2_buttons;
      logic [BTN_W-1:0] pad3_buttons;
      logic [1:0]       pad_select;
      logic [BTN_W-1:0] button_mask;
   } req_type;

   typedef struct packed {
      logic [BTN_W-1:0] held_buttons;
      logic [BTN_W-1:0] pressed_buttons;
      logic             pad_absent;
   } rsp_type;

   // Access request from the sequencer to the sample ring
   typedef struct packed {
      logic       wr_en;
      slot_type   wr_addr;
      sample_type wr_data;
      logic       rd_en;
      slot_type   rd_addr;
   } ring_req_type;

   // Advance a slot index around the ring
   function automatic slot_type next_slot(input slot_type s);
      slot_type r;
      if (s == SLOT_W'(SAMPLE_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

   // Pack the pad words of a sample transaction; pads beyond PAD_COUNT stay zero
   function automatic sample_type pack_sample(input req_type r);
      logic [BTN_W-1:0] words [4];
      sample_type       s;
      words[0] = r.pad0_buttons;
      words[1] = r.pad1_buttons;
      words[2] = r.pad2_buttons;
      words[3] = r.pad3_buttons;
      s = '0;
      for (int p = 0; p < PAD_COUNT; p++) begin
         s[p*BTN_W +: BTN_W] = words[p];
      end
      return s;
   endfunction

   // Pick one pad's word out of a sample
   function automatic logic [BTN_W-1:0] pad_word(input sample_type s, input logic [1:0] pad);
      return s[pad*BTN_W +: BTN_W];
   endfunction

endpackage

FILE: design/frame_button_edge_sampler.sv
// Frame button edge sampler: keeps a ring of polled button samples for up to
// four pads, latches per-frame pressed sets and answers per-pad queries.
// Usage:
//   req_*  : input transactions (sample, frame boundary, query), valid/stall.
//            req_stall is high while a frame walk or a query lookup runs.
//   rsp_*  : one result per query transaction, valid/stall, held in an
//            output register so a stalled result does not block samples.
//   csr_*  : write of connected_pads, valid/ready; csr_ready is always high.
// Transactions:
//   sample transaction : written straight into the ring memory.
//   query transaction  : one memory read into the result register, held
//                        back while a previous result is stalled.
//   frame transaction  : an empty frame needs no walk; otherwise the single
//                        read port walks the frame from its start sample to
//                        its end sample.
// Reset (synchronous, active high) clears pointers, the pressed set, the
// register and the result valid; slot 0 of the ring reads as zero until written.
// Depends on fbes_pkg, fbes_ring and fbes_ctrl.
module frame_button_edge_sampler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fbes_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fbes_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);

   fbes_pkg::ring_req_type ring_req;
   fbes_pkg::sample_type   rd_data;

   // Sample memory
   fbes_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_req (ring_req),
      .rd_data  (rd_data)
   );

   // Sequencer
   fbes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .ring_req  (ring_req),
      .rd_data   (rd_data)
   );

endmodule

FILE: design/fbes_ring.sv
// Sample ring: one synchronous memory of SAMPLE_SLOTS samples, one write and one
// read port, registered read data. Slot 0 reads as zero until first written.
// Depends on fbes_pkg.
module fbes_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  fbes_pkg::ring_req_type ring_req,
   output fbes_pkg::sample_type  rd_data
);

   fbes_pkg::sample_type ring_mem [fbes_pkg::SAMPLE_SLOTS];
   fbes_pkg::sample_type rd_data_ff;
   logic                 rd_zero_ff;
   logic                 slot0_written_ff;
   logic                 slot0_written_in;

   // Track the first write of slot 0, whose reset value is zero
   assign slot0_written_in = slot0_written_ff ||
                             (ring_req.wr_en && (ring_req.wr_addr == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_written_ff <= 1'b0;
      end else begin
         slot0_written_ff <= slot0_written_in;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (ring_req.wr_en) begin
         ring_mem[ring_req.wr_addr] <= ring_req.wr_data;
      end
   end

   // Read port, registered; data holds until the next read
   always_ff @(posedge clock) begin
      if (ring_req.rd_en) begin
         rd_data_ff <= ring_mem[ring_req.rd_addr];
         rd_zero_ff <= (ring_req.rd_addr == '0) && !slot0_written_ff;
      end
   end

   assign rd_data = rd_zero_ff ? '0 : rd_data_ff;

endmodule

FILE: design/fbes_ctrl.sv
// Sequencer of the frame button edge sampler: ring pointers, sample writes,
// frame walk with edge accumulation, query lookup and the result register.
// Depends on fbes_pkg; drives fbes_ring through a ring_req_type struct.
module fbes_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fbes_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fbes_pkg::rsp_type      rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [3:0]             csr_data,
   output fbes_pkg::ring_req_type ring_req,
   input  fbes_pkg::sample_type   rd_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_QUERY = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0]               state_ff, state_in;
   fbes_pkg::slot_type       start_ff, start_in;
   fbes_pkg::slot_type       end_ff, end_in;
   fbes_pkg::slot_type       newest_ff, newest_in;
   fbes_pkg::slot_type       walk_addr_ff, walk_addr_in;
   fbes_pkg::slot_type       rd_tag_ff, rd_tag_in;
   logic                     first_ff, first_in;
   fbes_pkg::sample_type     prev_ff, prev_in;
   fbes_pkg::sample_type     acc_ff, acc_in;
   fbes_pkg::sample_type     pressed_ff, pressed_in;
   logic [1:0]               pad_ff, pad_in;
   logic [fbes_pkg::BTN_W-1:0] mask_ff, mask_in;
   logic [3:0]               connected_ff, connected_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   fbes_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     rsp_free;
   logic                     pad_present;
   fbes_pkg::slot_type       sample_slot;
   fbes_pkg::sample_type     edge_bits;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign pad_present = (int'(pad_ff) < fbes_pkg::PAD_COUNT) && connected_ff[pad_ff];
   assign edge_bits   = rd_data & ~prev_ff;

   // Slot for a new sample: next slot, or the newest one if next is the frame start
   always_comb begin
      sample_slot = fbes_pkg::next_slot(newest_ff);
      if (sample_slot == start_ff) begin
         sample_slot = newest_ff;
      end
   end

   assign connected_in = (csr_valid && csr_ready) ? csr_data : connected_ff;

   // Sequence transactions
   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      newest_in    = newest_ff;
      walk_addr_in = walk_addr_ff;
      rd_tag_in    = rd_tag_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      pressed_in   = pressed_ff;
      pad_in       = pad_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ring_req     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  fbes_pkg::KIND_SAMPLE: begin
                     ring_req.wr_en   = 1'b1;
                     ring_req.wr_addr = sample_slot;
                     ring_req.wr_data = fbes_pkg::pack_sample(req_data);
                     newest_in        = sample_slot;
                  end
                  fbes_pkg::KIND_FRAME: begin
                     start_in   = end_ff;
                     end_in     = newest_ff;
                     pressed_in = '0;
                     if (newest_ff != end_ff) begin
                        // Read the new start first: it is the previous sample of the walk
                        ring_req.rd_en   = 1'b1;
                        ring_req.rd_addr = end_ff;
                        rd_tag_in        = end_ff;
                        walk_addr_in     = fbes_pkg::next_slot(end_ff);
                        first_in         = 1'b1;
                        acc_in           = '0;
                        state_in         = ST_WALK;
                     end
                  end
                  fbes_pkg::KIND_QUERY: begin
                     ring_req.rd_en   = 1'b1;
                     ring_req.rd_addr = end_ff;
                     pad_in           = req_data.pad_select;
                     mask_in          = req_data.button_mask;
                     state_in         = ST_QUERY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_QUERY: begin
            // Load the result register once it is free; read data holds meanwhile
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (pad_present) begin
                  rsp_data_in.held_buttons    = fbes_pkg::pad_word(rd_data, pad_ff) & mask_ff;
                  rsp_data_in.pressed_buttons = fbes_pkg::pad_word(pressed_ff, pad_ff) & mask_ff;
                  rsp_data_in.pad_absent      = 1'b0;
               end else begin
                  rsp_data_in.held_buttons    = '0;
                  rsp_data_in.pressed_buttons = '0;
                  rsp_data_in.pad_absent      = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            // Issue the next read until the frame end has been requested
            if (rd_tag_ff != end_ff) begin
               ring_req.rd_en   = 1'b1;
               ring_req.rd_addr = walk_addr_ff;
               rd_tag_in        = walk_addr_ff;
               walk_addr_in     = fbes_pkg::next_slot(walk_addr_ff);
            end
            // Accumulate rising edges of the sample that just arrived
            prev_in = rd_data;
            if (first_ff) begin
               first_in = 1'b0;
            end else begin
               acc_in = acc_ff | edge_bits;
               if (rd_tag_ff == end_ff) begin
                  pressed_in = acc_ff | edge_bits;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         end_ff       <= '0;
         newest_ff    <= '0;
         pressed_ff   <= '0;
         connected_ff <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         rd_tag_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         newest_ff    <= newest_in;
         pressed_ff   <= pressed_in;
         connected_ff <= connected_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         rd_tag_ff    <= rd_tag_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      walk_addr_ff <= walk_addr_in;
      prev_ff      <= prev_in;
      acc_ff       <= acc_in;
      pad_ff       <= pad_in;
      mask_ff      <= mask_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // A query transaction always goes to the lookup state
   a_query_enters_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.kind == fbes_pkg::KIND_QUERY)
      |=> (state_ff == ST_QUERY))
      else $error("query transaction did not start a lookup");

   // The first data of a walk is the frame start
   a_walk_starts_at_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && first_ff) |-> (rd_tag_ff == start_ff))
      else $error("frame walk did not begin at the frame start");

   // The walk ends once the frame end sample has been folded in
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && !first_ff && rd_tag_ff == end_ff) |=> (state_ff == ST_IDLE))
      else $error("frame walk ran past the frame end");

   // A new result only comes from a lookup
   a_result_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QUERY))
      else $error("result loaded outside a lookup");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for frame_button_edge_sampler: sample, frame and query traffic
// is checked against an in-bench model of the sample ring and the pressed set.
// Depends on fbes_pkg and the frame_button_edge_sampler RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = fbes_pkg::SAMPLE_SLOTS + 4;
   localparam int BLOCK_ITEMS = 258;

   // Tracks the ring, the frame window and the pressed set; holds the query answers
   // still owed by the block.
   class button_tracker;
      fbes_pkg::sample_type ring [fbes_pkg::SAMPLE_SLOTS];
      int                   start_slot;
      int                   end_slot;
      int                   newest_slot;
      fbes_pkg::sample_type pressed_set;
      logic [3:0]           pads_on;
      fbes_pkg::rsp_type    owed [$];
      int                   errors;

      function void clear();
         foreach (ring[i]) ring[i] = '0;
         start_slot  = 0;
         end_slot    = 0;
         newest_slot = 0;
         pressed_set = '0;
         pads_on     = '0;
         errors      = 0;
      endfunction

      function logic [fbes_pkg::BTN_W-1:0] lane(fbes_pkg::sample_type s, int pad);
         return s[pad*fbes_pkg::BTN_W +: fbes_pkg::BTN_W];
      endfunction

      function void set_pads(logic [3:0] v);
         pads_on = v;
      endfunction

      // Advance the model by one accepted transaction
      function void take_item(fbes_pkg::req_type r);
         int                          slot;
         int                          prev;
         int                          pad;
         fbes_pkg::sample_type        word;
         logic [fbes_pkg::BTN_W-1:0]  edges;
         fbes_pkg::rsp_type           answer;
         case (r.kind)
            fbes_pkg::KIND_SAMPLE: begin
               word = {r.pad3_buttons, r.pad2_buttons, r.pad1_buttons, r.pad0_buttons};
               for (int p = fbes_pkg::PAD_COUNT; p < 4; p++) begin
                  word[p*fbes_pkg::BTN_W +: fbes_pkg::BTN_W] = '0;
               end
               slot = (newest_slot + 1) % fbes_pkg::SAMPLE_SLOTS;
               // never step onto the frame start: overwrite the newest slot instead
               if (slot == start_slot) slot = newest_slot;
               ring[slot]  = word;
               newest_slot = slot;
            end
            fbes_pkg::KIND_FRAME: begin
               start_slot  = end_slot;
               end_slot    = newest_slot;
               pressed_set = '0;
               // OR the rising edges of every sample after the start up to the end
               if (end_slot != start_slot) begin
                  for (int p = 0; p < fbes_pkg::PAD_COUNT; p++) begin
                     edges = '0;
                     slot  = (start_slot + 1) % fbes_pkg::SAMPLE_SLOTS;
                     for (int n = 0; n < fbes_pkg::SAMPLE_SLOTS; n++) begin
                        prev  = (slot + fbes_pkg::SAMPLE_SLOTS - 1) % fbes_pkg::SAMPLE_SLOTS;
                        edges = edges | (lane(ring[slot], p) & ~lane(ring[prev], p));
                        if (slot == end_slot) break;
                        slot = (slot + 1) % fbes_pkg::SAMPLE_SLOTS;
                     end
                     pressed_set[p*fbes_pkg::BTN_W +: fbes_pkg::BTN_W] = edges;
                  end
               end
            end
            fbes_pkg::KIND_QUERY: begin
               pad    = r.pad_select;
               answer = '0;
               if (pad < fbes_pkg::PAD_COUNT && pads_on[pad]) begin
                  answer.held_buttons    = lane(ring[end_slot], pad) & r.button_mask;
                  answer.pressed_buttons = lane(pressed_set, pad) & r.button_mask;
               end else begin
                  answer.pad_absent = 1'b1;
               end
               owed.push_back(answer);
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted result with the oldest owed answer
      function void check_result(fbes_pkg::rsp_type got);
         fbes_pkg::rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: held %h pressed %h absent %b",
                     $time, got.held_buttons, got.pressed_buttons, got.pad_absent);
            return;
         end
         want = owed.pop_front();
         if (got.held_buttons !== want.held_buttons ||
             got.pressed_buttons !== want.pressed_buttons ||
             got.pad_absent !== want.pad_absent) begin
            errors++;
            $display({"%0t: result mismatch: expected held %h pressed %h absent %b, ",
                      "got held %h pressed %h absent %b"},
                     $time, want.held_buttons, want.pressed_buttons, want.pad_absent,
                     got.held_buttons, got.pressed_buttons, got.pad_absent);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fbes_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fbes_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [3:0]        csr_data = '0;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   logic [fbes_pkg::BTN_W-1:0] last_words [4] = '{default: '0};

   button_tracker tracker = new;

   frame_button_edge_sampler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // Check results, then feed accepted transactions to the model
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) tracker.check_result(rsp_data);
         if (req_valid && req_stall === 1'b0) tracker.take_item(req_data);
      end
   end

   function automatic fbes_pkg::req_type pack_item(
         input logic [1:0]                 kind,
         input logic [fbes_pkg::BTN_W-1:0] w0, w1, w2, w3,
         input logic [1:0]                 sel,
         input logic [fbes_pkg::BTN_W-1:0] mask);
      fbes_pkg::req_type r;
      r.kind         = kind;
      r.pad0_buttons = w0;
      r.pad1_buttons = w1;
      r.pad2_buttons = w2;
      r.pad3_buttons = w3;
      r.pad_select   = sel;
      r.button_mask  = mask;
      return r;
   endfunction

   // Random transaction; sample words often drift from the last sample by a few bits
   function automatic fbes_pkg::req_type make_item(input logic [1:0] kind);
      logic [fbes_pkg::BTN_W-1:0] w [4];
      logic [fbes_pkg::BTN_W-1:0] mask;
      for (int p = 0; p < 4; p++) begin
         if ($urandom_range(0, 1) == 1) begin
            w[p] = fbes_pkg::BTN_W'($urandom);
         end else begin
            w[p] = last_words[p] ^ fbes_pkg::BTN_W'($urandom & $urandom & $urandom);
         end
         if (kind == fbes_pkg::KIND_SAMPLE) last_words[p] = w[p];
      end
      mask = ($urandom_range(0, 3) == 0) ? '1 : fbes_pkg::BTN_W'($urandom);
      return pack_item(kind, w[0], w[1], w[2], w[3], 2'($urandom_range(0, 3)), mask);
   endfunction

   // Present one transaction and hold it until accepted; call and return at a falling edge
   task automatic send_item(input fbes_pkg::req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain owed results and let a frame walk finish
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.owed.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pads(input logic [3:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      tracker.set_pads(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly sample bursts closed by a frame and a few queries; some lone random items
   task automatic run_block(input int target);
      int         sent;
      int         bursts;
      int         asks;
      logic [1:0] kind;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 99) < 85) begin
            bursts = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20)
                                                 : $urandom_range(0, 6);
            asks   = $urandom_range(0, 3);
            repeat (bursts) send_item(make_item(fbes_pkg::KIND_SAMPLE));
            send_item(make_item(fbes_pkg::KIND_FRAME));
            repeat (asks) send_item(make_item(fbes_pkg::KIND_QUERY));
            sent += bursts + 1 + asks;
         end else begin
            kind = 2'($urandom_range(0, 3));
            send_item(make_item(kind));
            if (kind != KIND_UNUSED) sent++;
         end
      end
   endtask

   initial begin
      logic [3:0] pad_settings [6];
      pad_settings = '{4'hF, 4'h5, 4'hA, 4'h0, 4'h0, 4'hF};
      pad_settings[4] = 4'($urandom_range(0, 15));
      tracker.clear();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty frames, all-zero and all-one words, every pad, zero mask
      write_pads(4'hF);
      send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'd0, '1));
      send_item(pack_item(fbes_pkg::KIND_FRAME, '0, '0, '0, '0, 2'd0, '0));
      send_item(pack_item(fbes_pkg::KIND_SAMPLE, '0, '0, '0, '0, 2'd0, '0));
      send_item(pack_item(fbes_pkg::KIND_SAMPLE, '1, '1, '1, '1, 2'd3, '1));
      send_item(pack_item(fbes_pkg::KIND_SAMPLE, '0, '0, '0, '0, 2'd0, '0));
      send_item(pack_item(fbes_pkg::KIND_SAMPLE, 16'h0001, 16'h8000, 16'h5A5A, 16'hA5A5,
                          2'd1, '0));
      send_item(pack_item(fbes_pkg::KIND_FRAME, '1, '1, '1, '1, 2'd3, '1));
      for (int p = 0; p < 4; p++) begin
         send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'(p), '1));
      end
      send_item(pack_item(fbes_pkg::KIND_QUERY, '1, '1, '1, '1, 2'd2, '0));
      send_item(make_item(KIND_UNUSED));
      send_item(pack_item(fbes_pkg::KIND_SAMPLE, '1, '1, '1, '1, 2'd0, '0));
      send_item(pack_item(fbes_pkg::KIND_FRAME, '0, '0, '0, '0, 2'd0, '0));
      send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'd3, '1));
      send_item(pack_item(fbes_pkg::KIND_FRAME, '0, '0, '0, '0, 2'd0, '0));
      send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'd1, '1));
      settle();
      write_pads(4'h0);
      send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'd0, '1));
      send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'd3, '1));
      settle();
      write_pads(4'b1001);
      send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'd0, 16'h3C3C));
      send_item(pack_item(fbes_pkg::KIND_QUERY, '0, '0, '0, '0, 2'd1, '1));

      // Random: three idle profiles, two pad settings each
      for (int b = 0; b < 6; b++) begin
         settle();
         case (b / 2)
            0: begin
               send_idle_pct = 6;
               rsp_idle_pct  = 57;
            end
            1: begin
               send_idle_pct = 57;
               rsp_idle_pct  = 6;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         write_pads(pad_settings[b]);
         run_block(BLOCK_ITEMS);
      end

      settle();
      if (tracker.errors == 0 && tracker.owed.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
design/fbes_pkg.sv
design/fbes_ring.sv
design/fbes_ctrl.sv
design/frame_button_edge_sampler.sv
bench/tb_top.sv
